[design/cse_pkg.sv]
package cse_pkg;

    localparam int MAX_ORBITALS_DEFAULT = 64;
    localparam int IRREP_BITS_DEFAULT   = 3;
    localparam int WORD_BITS            = 64;
    localparam int INDEX_BITS           = 6;
    localparam int LABEL_BITS           = 3;
    localparam int COUNT_BITS           = 7;
    localparam int QUEUE_DEPTH          = 2;

    // Input opcodes as they arrive on the stream.
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_NEXT    = 2'd2;

    // Register index taken from the word address.
    localparam logic REG_NUM_ORBITALS  = 1'b0;
    localparam logic REG_NUM_ELECTRONS = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_RESTART,
        CMD_NEXT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [INDEX_BITS-1:0]  index;
        logic [LABEL_BITS-1:0]  label;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_ADVANCE
    } back_state_t;

    typedef struct packed {
        logic advancing;
        logic exhausted;
        logic out_load;
    } back_status_t;

endpackage

[design/combination_string_enumerator_core.sv]
// Enumerates every word of n orbital bits with exactly k bits set, in increasing order,
// together with the XOR of the irrep labels of the set orbitals.
// Input stream: s_tuser carries the opcode (load label, restart, next word); s_tdata
// carries the orbital index and the label for a load. Output stream: one word per
// next request; m_tuser is low once the list is exhausted, m_tlast marks the final word.
// n and k are written over the APB port at byte addresses 0 and 4; the user must write
// them only while the block is idle, as the block does not enforce it. A front stage
// decodes each input word into a two-entry command queue, so s_tready stays high while
// the queue has room even when the output side stalls. The back end executes one
// command at a time: a load or restart completes in the idle state; a next word takes
// the two-step advance (low bit, ripple add and symmetry XOR tree, then the shift and
// range test) and lands in the output register, and no new command is taken until it
// is done. A stalled receiver holds the output register; the back end then waits, the
// queue fills and s_tready falls.
// Reset zeroes the label table, n, k, the word and m_tvalid; the list starts exhausted.
module combination_string_enumerator_core #(
    parameter int MAX_ORBITALS = cse_pkg::MAX_ORBITALS_DEFAULT,
    parameter int IRREP_BITS   = cse_pkg::IRREP_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // orbital_index[5:0], irrep_label[8:6], zero pad
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // occupation[63:0], string_symmetry[66:64], zero pad
    output logic [0:0]  m_tuser,   // word_valid[0]
    output logic        m_tlast,   // is_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [cse_pkg::COUNT_BITS-1:0] num_orbitals_reg;
    logic [cse_pkg::COUNT_BITS-1:0] num_electrons_reg;
    logic                           cfg_write;

    logic                           cmd_valid;
    logic                           cmd_pop;
    cse_pkg::cmd_t                  cmd;
    cse_pkg::back_status_t          status;

    logic [cse_pkg::WORD_BITS-1:0]  occupation;
    logic [cse_pkg::LABEL_BITS-1:0] symmetry;
    logic                           word_valid;
    logic                           is_last;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_orbitals_reg  <= '0;
            num_electrons_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == cse_pkg::REG_NUM_ORBITALS)
            begin
                num_orbitals_reg <= pwdata[cse_pkg::COUNT_BITS-1:0];
            end
            else
            begin
                num_electrons_reg <= pwdata[cse_pkg::COUNT_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == cse_pkg::REG_NUM_ELECTRONS)
        begin
            prdata = 32'(num_electrons_reg);
        end
        else
        begin
            prdata = 32'(num_orbitals_reg);
        end
    end

    cse_front #(
        .MAX_ORBITALS (MAX_ORBITALS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (s_tuser),
        .in_index  (s_tdata[5:0]),
        .in_label  (s_tdata[8:6]),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    cse_back #(
        .MAX_ORBITALS (MAX_ORBITALS),
        .IRREP_BITS   (IRREP_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop),
        .num_orbitals   (num_orbitals_reg),
        .num_electrons  (num_electrons_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_occupation (occupation),
        .out_symmetry   (symmetry),
        .out_word_valid (word_valid),
        .out_is_last    (is_last),
        .status         (status)
    );

    assign m_tdata    = {5'd0, symmetry, occupation};
    assign m_tuser[0] = word_valid;
    assign m_tlast    = is_last;

    // An exhausted list answers with an all-zero word.
    a_empty_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !word_valid) |-> (occupation == '0 && !is_last && symmetry == '0))
        else $error("exhausted reply carries non-zero fields");

    // A word that is not the last leaves the list open for the next request.
    a_open_after_word: assert property (@(posedge clk) disable iff (!rst_n)
        status.out_load |=> (m_tuser[0] && !m_tlast) == (m_tuser[0] && !status.exhausted))
        else $error("list state disagrees with last flag");

    // The second advance step finishes as soon as the output register is free.
    a_advance_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (status.advancing && (!m_tvalid || m_tready)) |=> (!status.advancing && m_tvalid))
        else $error("advance did not complete into a free output register");

    // Nothing is popped from the queue while an advance is in flight.
    a_no_pop_advancing: assert property (@(posedge clk) disable iff (!rst_n)
        status.advancing |-> !cmd_pop)
        else $error("command popped during an advance");

endmodule

[design/cse_front.sv]
module cse_front #(
    parameter int MAX_ORBITALS = cse_pkg::MAX_ORBITALS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        in_opcode,
    input  logic [cse_pkg::INDEX_BITS-1:0]    in_index,
    input  logic [cse_pkg::LABEL_BITS-1:0]    in_label,
    output logic                              cmd_valid,
    output cse_pkg::cmd_t                     cmd,
    input  logic                              cmd_pop
);

    localparam logic [cse_pkg::COUNT_BITS-1:0] MAX_N = cse_pkg::COUNT_BITS'(MAX_ORBITALS);

    cse_pkg::cmd_t entry_reg [cse_pkg::QUEUE_DEPTH];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    cse_pkg::cmd_t decoded;
    logic          keep;
    logic          push;

    // Opcode three and loads beyond the table are taken and dropped here.
    always_comb
    begin
        decoded.index = in_index;
        decoded.label = in_label;
        decoded.kind  = cse_pkg::CMD_LOAD;
        keep          = 1'b0;
        unique case (in_opcode)
            cse_pkg::OP_LOAD:
            begin
                decoded.kind = cse_pkg::CMD_LOAD;
                keep         = ({1'b0, in_index} < MAX_N);
            end
            cse_pkg::OP_RESTART:
            begin
                decoded.kind = cse_pkg::CMD_RESTART;
                keep         = 1'b1;
            end
            cse_pkg::OP_NEXT:
            begin
                decoded.kind = cse_pkg::CMD_NEXT;
                keep         = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_ready  = (count_reg != 2'(cse_pkg::QUEUE_DEPTH));
    assign push      = in_valid && in_ready && keep;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

[design/cse_back.sv]
module cse_back #(
    parameter int MAX_ORBITALS = cse_pkg::MAX_ORBITALS_DEFAULT,
    parameter int IRREP_BITS   = cse_pkg::IRREP_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  cse_pkg::cmd_t                     cmd,
    output logic                              cmd_pop,
    input  logic [cse_pkg::COUNT_BITS-1:0]    num_orbitals,
    input  logic [cse_pkg::COUNT_BITS-1:0]    num_electrons,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cse_pkg::WORD_BITS-1:0]     out_occupation,
    output logic [cse_pkg::LABEL_BITS-1:0]    out_symmetry,
    output logic                              out_word_valid,
    output logic                              out_is_last,
    output cse_pkg::back_status_t             status
);

    localparam int ENTRY_W = (IRREP_BITS < cse_pkg::LABEL_BITS) ? IRREP_BITS
                                                                 : cse_pkg::LABEL_BITS;
    localparam int WB = cse_pkg::WORD_BITS;
    localparam logic [cse_pkg::COUNT_BITS-1:0] MAX_N = cse_pkg::COUNT_BITS'(MAX_ORBITALS);

    logic [ENTRY_W-1:0] irrep_reg [MAX_ORBITALS];

    cse_pkg::back_state_t state_reg, state_next;
    logic [WB-1:0]        word_reg, word_next;
    logic                 exhausted_reg, exhausted_next;

    logic [WB-1:0]               occ_reg, occ_next;
    logic [cse_pkg::LABEL_BITS-1:0] sym_out_reg, sym_out_next;
    logic                        wv_reg, wv_next;
    logic                        last_reg, last_next;
    logic                        out_valid_reg, out_valid_next;

    // First advance step results.
    logic [WB-1:0]               sum_reg;
    logic                        carry_reg;
    logic                        nonzero_reg;
    logic [5:0]                  shift_reg;
    logic [cse_pkg::LABEL_BITS-1:0] sym_reg;
    logic                        capture;

    logic [WB-1:0]               low_bit;
    logic [WB:0]                 sum_wide;
    logic [5:0]                  low_pos;
    logic [cse_pkg::LABEL_BITS-1:0] sym_comb;
    logic [WB-1:0]               next_word;
    logic                        has_next;
    logic                        table_we;
    logic                        out_free;
    logic                        out_load;

    always_comb
    begin
        low_bit  = word_reg & (~word_reg + 1'b1);
        sum_wide = {1'b0, word_reg} + {1'b0, low_bit};
        low_pos  = 6'd0;
        for (int i = 0; i < WB; i++)
        begin
            if (low_bit[i])
            begin
                low_pos = low_pos | 6'(i);
            end
        end
        sym_comb = '0;
        for (int i = 0; i < MAX_ORBITALS; i++)
        begin
            if (word_reg[i])
            begin
                sym_comb = sym_comb ^ cse_pkg::LABEL_BITS'(irrep_reg[i]);
            end
        end
    end

    // Gosper step: the division by the low bit is a right shift by its position.
    always_comb
    begin
        next_word = ((((word_reg ^ sum_reg) >> 2) >> shift_reg) | sum_reg);
        has_next  = nonzero_reg && !carry_reg
                    && ((next_word & ({WB{1'b1}} << num_orbitals)) == '0);
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        word_next      = word_reg;
        exhausted_next = exhausted_reg;
        occ_next       = occ_reg;
        sym_out_next   = sym_out_reg;
        wv_next        = wv_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd_pop        = 1'b0;
        capture        = 1'b0;
        table_we       = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            cse_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        cse_pkg::CMD_LOAD:
                        begin
                            cmd_pop  = 1'b1;
                            table_we = 1'b1;
                        end
                        cse_pkg::CMD_RESTART:
                        begin
                            cmd_pop = 1'b1;
                            if (num_electrons > num_orbitals || num_orbitals > MAX_N)
                            begin
                                exhausted_next = 1'b1;
                                word_next      = '0;
                            end
                            else
                            begin
                                exhausted_next = 1'b0;
                                word_next      = ~({WB{1'b1}} << num_electrons);
                            end
                        end
                        cse_pkg::CMD_NEXT:
                        begin
                            if (!exhausted_reg)
                            begin
                                cmd_pop    = 1'b1;
                                capture    = 1'b1;
                                state_next = cse_pkg::BK_ADVANCE;
                            end
                            else if (out_free)
                            begin
                                cmd_pop        = 1'b1;
                                out_valid_next = 1'b1;
                                out_load       = 1'b1;
                                occ_next       = '0;
                                sym_out_next   = '0;
                                wv_next        = 1'b0;
                                last_next      = 1'b0;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            cse_pkg::BK_ADVANCE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_load       = 1'b1;
                    occ_next       = word_reg;
                    sym_out_next   = sym_reg;
                    wv_next        = 1'b1;
                    last_next      = !has_next;
                    state_next     = cse_pkg::BK_IDLE;
                    if (has_next)
                    begin
                        word_next = next_word;
                    end
                    else
                    begin
                        exhausted_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = cse_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cse_pkg::BK_IDLE;
            word_reg      <= '0;
            exhausted_reg <= 1'b1;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_ORBITALS; i++)
            begin
                irrep_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            exhausted_reg <= exhausted_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < MAX_ORBITALS; i++)
            begin
                if (table_we && cmd.index == cse_pkg::INDEX_BITS'(i))
                begin
                    irrep_reg[i] <= cmd.label[ENTRY_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        occ_reg     <= occ_next;
        sym_out_reg <= sym_out_next;
        wv_reg      <= wv_next;
        last_reg    <= last_next;
        if (capture)
        begin
            sum_reg     <= sum_wide[WB-1:0];
            carry_reg   <= sum_wide[WB];
            nonzero_reg <= (word_reg != '0);
            shift_reg   <= low_pos;
            sym_reg     <= sym_comb;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_occupation = occ_reg;
    assign out_symmetry   = sym_out_reg;
    assign out_word_valid = wv_reg;
    assign out_is_last    = last_reg;

    assign status = '{advancing: (state_reg == cse_pkg::BK_ADVANCE),
                      exhausted: exhausted_reg,
                      out_load:  out_load};

endmodule
